FILE: design/plle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plle_pkg
// shared types and constants of the positional list engine
// ----------------------------------------------------------------------------
package plle_pkg;

	localparam int CAP_DEF = 16;
	localparam int OP_W    = 3;
	localparam int VAL_W   = 32;
	localparam int POS_W   = 8;
	localparam int STAT_W  = 2;

	typedef enum logic [OP_W-1:0] {
		OP_INS_HEAD = 3'd0,
		OP_INS_TAIL = 3'd1,
		OP_INS_POS  = 3'd2,
		OP_DEL_POS  = 3'd3,
		OP_DEL_HEAD = 3'd4,
		OP_DEL_TAIL = 3'd5,
		OP_DUMP     = 3'd6
	} opcode_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK     = 2'd0,
		STAT_EMPTY  = 2'd1,
		STAT_BADPOS = 2'd2,
		STAT_FULL   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INS,
		CELL_DEL,
		CELL_ROT
	} cell_op_t;

	// command broadcast to every cell of the chain
	typedef struct packed {
		cell_op_t                op;
		logic [POS_W-1:0]        idx;
		logic signed [VAL_W-1:0] value;
	} cell_ctl_t;

	typedef enum logic {
		ST_IDLE,
		ST_DUMP
	} state_t;

endpackage

FILE: design/plle_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plle_in_if
// command channel: opcode, value and position with valid/ready
// ----------------------------------------------------------------------------
interface plle_in_if;
	logic                            valid;
	logic                            ready;
	logic [plle_pkg::OP_W-1:0]       opcode;
	logic signed [plle_pkg::VAL_W-1:0] value;
	logic [plle_pkg::POS_W-1:0]      position;

	modport source (output valid, output opcode, output value, output position, input ready);
	modport sink   (input valid, input opcode, input value, input position, output ready);
endinterface

FILE: design/plle_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plle_out_if
// result channel: status, element and last mark with valid/ready
// ----------------------------------------------------------------------------
interface plle_out_if;
	logic                              valid;
	logic                              ready;
	logic [plle_pkg::STAT_W-1:0]       status;
	logic signed [plle_pkg::VAL_W-1:0] element;
	logic                              last;

	modport source (output valid, output status, output element, output last, input ready);
	modport sink   (input valid, input status, input element, input last, output ready);
endinterface

FILE: design/plle_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plle_cell
// one storage slot of the list; takes from its left or right neighbor
// ----------------------------------------------------------------------------
module plle_cell #(
	parameter int IDX = 0
) (
	input  logic                              clk,
	input  plle_pkg::cell_ctl_t               ctl,
	input  logic signed [plle_pkg::VAL_W-1:0] left,
	input  logic signed [plle_pkg::VAL_W-1:0] right,
	input  logic signed [plle_pkg::VAL_W-1:0] head,
	output logic signed [plle_pkg::VAL_W-1:0] value
);
	import plle_pkg::*;

	localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

	logic signed [VAL_W-1:0] val_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_INS: begin
				// open a gap at idx, everything behind moves one slot back
				if (MY_IDX > ctl.idx) begin
					val_q <= left;
				end else if (MY_IDX == ctl.idx) begin
					val_q <= ctl.value;
				end
			end
			CELL_DEL: begin
				if (MY_IDX >= ctl.idx) begin
					val_q <= right;
				end
			end
			CELL_ROT: begin
				// idx holds the tail slot, which takes the old head
				if (MY_IDX == ctl.idx) begin
					val_q <= head;
				end else if (MY_IDX < ctl.idx) begin
					val_q <= right;
				end
			end
			default: begin
				val_q <= val_q;
			end
		endcase
	end

	assign value = val_q;

endmodule

FILE: design/positional_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine
// bounded ordered list of signed 32-bit values held in a chain of cells
// ----------------------------------------------------------------------------
// result: an edit is answered in the cycle after its command is accepted
// throughput: one edit per cycle when the result side keeps up; a dump of
//   count elements streams one element per cycle, also only while the
//   result side keeps up, each taken from the head as the chain rotates
// reset: arst_n clears the element count and the control state; cell
//   contents are not reset and are only read below the count
// ----------------------------------------------------------------------------
module positional_list_engine #(
	parameter int CAPACITY = plle_pkg::CAP_DEF
) (
	input logic        clk,
	input logic        arst_n,
	plle_in_if.sink    cmd,
	plle_out_if.source rsp
);
	import plle_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

	// control state
	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [CNT_W-1:0] dump_idx_q;

	// output register
	logic                    out_vld_q;
	logic [STAT_W-1:0]       out_stat_q;
	logic signed [VAL_W-1:0] out_elem_q;
	logic                    out_last_q;

	// next output values
	logic                    out_load;
	status_t                 out_stat_d;
	logic signed [VAL_W-1:0] out_elem_d;
	logic                    out_last_d;

	logic       out_free;
	logic       cmd_fire;
	logic       dump_start;
	logic       dump_step;
	logic       dump_last;
	logic       full;
	logic       empty;
	logic [POS_W-1:0] cnt_p;
	logic       ins_pos_bad;
	logic       del_pos_bad;
	opcode_t    op;
	cell_ctl_t  cell_ctl;

	// chain wiring
	logic signed [VAL_W-1:0] vals [CAPACITY];

	// output register can take a new result this cycle
	assign out_free = !out_vld_q || rsp.ready;
	assign cmd.ready = (state_q == ST_IDLE) && out_free;
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign op        = opcode_t'(cmd.opcode);

	assign full  = (count_q == CNT_FULL);
	assign empty = (count_q == '0);
	assign cnt_p = POS_W'(count_q);

	// positions are one-based; insert allows count+1, delete stops at count
	assign ins_pos_bad = (cmd.position == '0) || (cmd.position > cnt_p + POS_W'(1));
	assign del_pos_bad = (cmd.position == '0) || (cmd.position > cnt_p);

	assign dump_start = cmd_fire && (op == OP_DUMP) && !empty;
	assign dump_step  = (state_q == ST_DUMP) && out_free;
	assign dump_last  = (dump_idx_q == count_q - CNT_W'(1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (dump_start) begin
					state_d = ST_DUMP;
				end
			end
			ST_DUMP: begin
				if (dump_step && dump_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs: result, cell command and count update
	always_comb begin
		out_load       = 1'b0;
		out_stat_d     = STAT_OK;
		out_elem_d     = '0;
		out_last_d     = 1'b1;
		count_d        = count_q;
		cell_ctl.op    = CELL_HOLD;
		cell_ctl.idx   = '0;
		cell_ctl.value = cmd.value;

		unique case (state_q)
			ST_IDLE: begin
				if (cmd_fire) begin
					out_load = 1'b1;
					case (op)
						OP_INS_HEAD, OP_INS_TAIL: begin
							if (full) begin
								out_stat_d = STAT_FULL;
							end else begin
								cell_ctl.op  = CELL_INS;
								cell_ctl.idx = (op == OP_INS_HEAD) ? '0 : cnt_p;
								count_d      = count_q + CNT_W'(1);
							end
						end
						OP_INS_POS: begin
							// position check wins over fullness
							if (ins_pos_bad) begin
								out_stat_d = STAT_BADPOS;
							end else if (full) begin
								out_stat_d = STAT_FULL;
							end else begin
								cell_ctl.op  = CELL_INS;
								cell_ctl.idx = cmd.position - POS_W'(1);
								count_d      = count_q + CNT_W'(1);
							end
						end
						OP_DEL_POS: begin
							if (empty) begin
								out_stat_d = STAT_EMPTY;
							end else if (del_pos_bad) begin
								out_stat_d = STAT_BADPOS;
							end else begin
								cell_ctl.op  = CELL_DEL;
								cell_ctl.idx = cmd.position - POS_W'(1);
								count_d      = count_q - CNT_W'(1);
							end
						end
						OP_DEL_HEAD, OP_DEL_TAIL: begin
							if (empty) begin
								out_stat_d = STAT_EMPTY;
							end else begin
								cell_ctl.op  = CELL_DEL;
								cell_ctl.idx = (op == OP_DEL_HEAD) ? '0 : cnt_p - POS_W'(1);
								count_d      = count_q - CNT_W'(1);
							end
						end
						OP_DUMP: begin
							// a non-empty list streams from the dump state instead
							out_load   = empty;
							out_stat_d = STAT_EMPTY;
						end
						default: begin
							// unused opcode is swallowed without a result
							out_load = 1'b0;
						end
					endcase
				end
			end
			ST_DUMP: begin
				if (dump_step) begin
					// head goes out, the chain rotates so the list is whole again
					// once every element has gone out
					out_load     = 1'b1;
					out_elem_d   = vals[0];
					out_last_d   = dump_last;
					cell_ctl.op  = CELL_ROT;
					cell_ctl.idx = cnt_p - POS_W'(1);
				end
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			dump_idx_q <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (dump_start) begin
				dump_idx_q <= '0;
			end else if (dump_step) begin
				dump_idx_q <= dump_idx_q + CNT_W'(1);
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_stat_q <= out_stat_d;
			out_elem_q <= out_elem_d;
			out_last_q <= out_last_d;
		end
	end

	assign rsp.valid   = out_vld_q;
	assign rsp.status  = out_stat_q;
	assign rsp.element = out_elem_q;
	assign rsp.last    = out_last_q;

	// chain of cells, slot 0 is the head
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [VAL_W-1:0] left_val;
		logic signed [VAL_W-1:0] right_val;

		if (i == 0) begin : g_first
			assign left_val = cmd.value;
		end else begin : g_mid_l
			assign left_val = vals[i-1];
		end

		if (i == CAPACITY - 1) begin : g_end
			assign right_val = vals[i];
		end else begin : g_mid_r
			assign right_val = vals[i+1];
		end

		plle_cell #(
			.IDX (i)
		) u_cell (
			.clk   (clk),
			.ctl   (cell_ctl),
			.left  (left_val),
			.right (right_val),
			.head  (vals[0]),
			.value (vals[i])
		);
	end

endmodule

FILE: design/plle_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plle_chk
// port-level checks of the positional list engine, bound to the top level
// ----------------------------------------------------------------------------
module plle_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              cmd_valid,
	input logic                              cmd_ready,
	input logic [plle_pkg::OP_W-1:0]         cmd_opcode,
	input logic                              rsp_valid,
	input logic                              rsp_ready,
	input logic [plle_pkg::STAT_W-1:0]       rsp_status,
	input logic signed [plle_pkg::VAL_W-1:0] rsp_element,
	input logic                              rsp_last
);
	import plle_pkg::*;

	logic cmd_edit;

	// edit opcodes sit below the dump code, the unused code above it
	assign cmd_edit = cmd_valid && cmd_ready && (cmd_opcode < OP_DUMP);

	// stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_element) && $stable(rsp_last))
		else $error("result changed while stalled");

	// a non-ok status is always a single closing transaction with no element
	a_status_only: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != STAT_OK) |-> rsp_last && (rsp_element == '0))
		else $error("status result carries element or lacks last");

	// an edit answers in the next cycle with a single transaction
	a_edit_resp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_edit |=> rsp_valid && rsp_last)
		else $error("edit result missing");

	// no command is taken while a dump stream is open
	a_dump_block: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_last |-> !cmd_ready)
		else $error("command accepted during dump");

endmodule

bind positional_list_engine plle_chk u_plle_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_valid   (cmd.valid),
	.cmd_ready   (cmd.ready),
	.cmd_opcode  (cmd.opcode),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_status  (rsp.status),
	.rsp_element (rsp.element),
	.rsp_last    (rsp.last)
);
